/* design/awu_pkg.sv */
// Shared types, constants and saturation helpers for the Adam weight-update unit.
package awu_pkg;

   localparam int ENTRIES   = 4096;
   localparam int ADDR_W    = $clog2(ENTRIES);
   localparam int WORD_W    = 32;
   localparam int BETA_W    = 16;
   localparam int FRAC_W    = 24;
   localparam int BETA_ONE  = 65536;
   localparam int RAD_W     = 56;
   localparam int ROOT_W    = 28;
   localparam int SQ_STEPS  = 28;
   localparam int QUO_W     = 34;
   localparam int NUM_W     = 64;
   localparam int RD_LAT    = SQ_STEPS + QUO_W + 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [QUO_W-1:0] STEP_LIMIT = QUO_W'(64'h2_0000_0000);
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BETA_FIRST       = 3'd0,
      CSR_BETA_SECOND      = 3'd1,
      CSR_LEARNING_RATE    = 3'd2,
      CSR_EPSILON_TERM     = 3'd3,
      CSR_BIAS_CORR_FIRST  = 3'd4,
      CSR_BIAS_CORR_SECOND = 3'd5
   } csr_index_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [ADDR_W-1:0]       idx;
      logic [WORD_W-1:0]       load_weight;
      logic [WORD_W-1:0]       moment;
      logic [WORD_W-1:0]       velocity;
   } meta_type;

   typedef struct packed {
      meta_type meta;
      logic     neg;
      logic     fault;
   } step_ctl_type;

   function automatic logic [WORD_W-1:0] sat_s32(input logic signed [63:0] v);
      if (v > S32_MAX) begin
         return WORD_W'(S32_MAX);
      end else if (v < S32_MIN) begin
         return WORD_W'(S32_MIN);
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

   function automatic logic [WORD_W-1:0] sat_u32(input logic [63:0] v);
      if (|v[63:WORD_W]) begin
         return '1;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

endpackage

/* design/awu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module awu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/awu_root_div.sv */
// Pipelined square root of the denominator followed by pipelined step division.
module awu_root_div import awu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  step_ctl_type       in_ctl,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [RAD_W-1:0]   in_rad,
   output logic               out_valid,
   output step_ctl_type       out_ctl,
   output logic [QUO_W-1:0]   out_quo
);

   logic         valid_ff [RD_LAT];
   step_ctl_type ctl_ff   [RD_LAT];

   logic [RAD_W-1:0] sq_rem_ff [SQ_STEPS];
   logic [RAD_W-1:0] sq_res_ff [SQ_STEPS];
   logic [NUM_W-1:0] sq_num_ff [SQ_STEPS];

   logic [ROOT_W-1:0] dv_rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]  dv_qn_ff   [QUO_W+1];
   logic [ROOT_W-1:0] dv_root_ff [QUO_W+1];
   logic              dv_ovf_ff  [QUO_W+1];

   logic [QUO_W-1:0]  quo_ff;
   logic [ROOT_W-1:0] root_in;
   logic              ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RD_LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < RD_LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= in_ctl;
         for (int k = 1; k < RD_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [RAD_W-1:0] rem_src;
      logic [RAD_W-1:0] res_src;
      logic [NUM_W-1:0] num_src;
      logic [RAD_W:0]   trial;
      logic [RAD_W-1:0] rem_in;
      logic [RAD_W-1:0] res_in;
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);

      if (k == 0) begin : g_first
         assign rem_src = in_rad;
         assign res_src = '0;
         assign num_src = in_num;
      end else begin : g_next
         assign rem_src = sq_rem_ff[k-1];
         assign res_src = sq_res_ff[k-1];
         assign num_src = sq_num_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, res_src} + {1'b0, BIT};
         if ({1'b0, rem_src} >= trial) begin
            rem_in = rem_src - trial[RAD_W-1:0];
            res_in = (res_src >> 1) + BIT;
         end else begin
            rem_in = rem_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_rem_ff[k] <= rem_in;
            sq_res_ff[k] <= res_in;
            sq_num_ff[k] <= num_src;
         end
      end
   end

   always_comb begin
      root_in = sq_res_ff[SQ_STEPS-1][ROOT_W-1:0];
      ovf_in  = sq_num_ff[SQ_STEPS-1][NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(root_in);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_rem_ff[0]  <= sq_num_ff[SQ_STEPS-1][QUO_W+ROOT_W-1:QUO_W];
         dv_qn_ff[0]   <= sq_num_ff[SQ_STEPS-1][QUO_W-1:0];
         dv_root_ff[0] <= root_in;
         dv_ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar i = 1; i <= QUO_W; i++) begin : g_div
      logic [ROOT_W:0]   part;
      logic              take;
      logic [ROOT_W:0]   diff;
      logic [ROOT_W-1:0] rem_in;

      always_comb begin
         part   = {dv_rem_ff[i-1], dv_qn_ff[i-1][QUO_W-1]};
         take   = part >= {1'b0, dv_root_ff[i-1]};
         diff   = part - {1'b0, dv_root_ff[i-1]};
         rem_in = take ? diff[ROOT_W-1:0] : part[ROOT_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_ff[i]  <= rem_in;
            dv_qn_ff[i]   <= {dv_qn_ff[i-1][QUO_W-2:0], take};
            dv_root_ff[i] <= dv_root_ff[i-1];
            dv_ovf_ff[i]  <= dv_ovf_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (dv_ovf_ff[QUO_W] || (dv_qn_ff[QUO_W] > STEP_LIMIT)) begin
            quo_ff <= STEP_LIMIT;
         end else begin
            quo_ff <= dv_qn_ff[QUO_W];
         end
      end
   end

   assign out_valid = valid_ff[RD_LAT-1];
   assign out_ctl   = ctl_ff[RD_LAT-1];
   assign out_quo   = quo_ff;

endmodule

/* design/adam_weight_update_unit.sv */
// Top level of the Adam weight-update unit: command pipeline, state memories and result register.
//
// One request is taken every clock cycle while the pipeline moves, and its response leaves the
// result register; the pipeline moves only while the result register is empty or being taken, so
// a held response stalls every stage and the request side together. The root-division block holds
// the 28-step square root and the 34-step division, one step per stage. Moments are read five
// stages in and written back in the next stage, the weight is read and written at the end of the
// pipeline, and each memory forwards the value written by the request just ahead, so requests to
// the same entry may follow each other in consecutive cycles. Memory contents are undefined until
// an entry is loaded; there is no clearing pass after reset.
module adam_weight_update_unit import awu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // entry_index, activation, out_gradient, load_weight, zero pad
   input  logic [111:0]         req_tdata,
   // cmd
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // weight_value, moment_value, velocity_value
   output logic [95:0]          rsp_tdata,
   // div_fault
   output logic [0:0]           rsp_tuser,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wr_data
);

   localparam int LAST = 11;

   logic [BETA_W-1:0] beta_first_ff;
   logic [BETA_W-1:0] beta_second_ff;
   logic [WORD_W-1:0] learning_rate_ff;
   logic [WORD_W-1:0] epsilon_term_ff;
   logic [WORD_W-1:0] bias_corr_first_ff;
   logic [WORD_W-1:0] bias_corr_second_ff;

   logic     advance;
   logic     valid_ff [1:LAST];
   meta_type meta_ff  [1:LAST];
   meta_type meta1_in;
   meta_type meta7_in;

   logic signed [63:0] s1_prod_ff;
   logic signed [31:0] s2_g_ff;
   logic [63:0]        s3_gg_ff;
   logic signed [49:0] s3_cm_ff;
   logic signed [49:0] s4_cm_ff;
   logic signed [49:0] s5_cm_ff;
   logic signed [49:0] s6_cm_ff;
   logic [WORD_W-1:0]  s4_g2_ff;
   logic [48:0]        s5_cv_ff;
   logic [48:0]        s6_cv_ff;
   logic signed [63:0] s8_mhat_ff;
   logic [63:0]        s8_vhat_ff;
   logic [WORD_W-1:0]  s9_mhat_ff;
   logic [WORD_W-1:0]  s9_vhat_ff;
   logic [WORD_W-1:0]  s10_sum_ff;
   logic [WORD_W-1:0]  s10_mag_ff;
   logic               s10_neg_ff;
   logic [NUM_W-1:0]   s11_num_ff;
   logic [RAD_W-1:0]   s11_rad_ff;
   logic               s11_neg_ff;
   logic               s11_fault_ff;

   logic [BETA_W:0]    b1c_in;
   logic [BETA_W:0]    b2c_in;
   logic signed [49:0] cm_in;
   logic [48:0]        cv_in;
   logic [WORD_W:0]    sum_in;

   logic [2*WORD_W-1:0] mv_q;
   logic                mv_fwd;
   logic [WORD_W-1:0]   m_old;
   logic [WORD_W-1:0]   v_old;
   logic signed [49:0]  m_sum_in;
   logic [48:0]         v_sum_in;
   logic                mv_wr_en;

   step_ctl_type      rd_ctl_in;
   logic              rd_valid;
   step_ctl_type      rd_ctl;
   logic [QUO_W-1:0]  rd_quo;

   logic              w_valid_ff;
   step_ctl_type      w_ctl_ff;
   logic [QUO_W-1:0]  w_quo_ff;
   logic [WORD_W-1:0] w_q;
   logic              w_fwd;
   logic [WORD_W-1:0] w_old;
   logic signed [34:0] delta_in;
   logic signed [63:0] w_diff_in;
   logic [WORD_W-1:0] w_new_in;
   logic              fault_in;
   logic              w_wr_en;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_weight_ff;
   logic [WORD_W-1:0] rsp_moment_ff;
   logic [WORD_W-1:0] rsp_velocity_ff;
   logic              rsp_fault_ff;
   logic [ADDR_W-1:0] rsp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_first_ff       <= BETA_W'(58982);
         beta_second_ff      <= BETA_W'(65470);
         learning_rate_ff    <= WORD_W'(16777);
         epsilon_term_ff     <= WORD_W'(1);
         bias_corr_first_ff  <= WORD_W'(16777216);
         bias_corr_second_ff <= WORD_W'(16777216);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BETA_FIRST:       beta_first_ff       <= csr_wr_data[BETA_W-1:0];
            CSR_BETA_SECOND:      beta_second_ff      <= csr_wr_data[BETA_W-1:0];
            CSR_LEARNING_RATE:    learning_rate_ff    <= csr_wr_data;
            CSR_EPSILON_TERM:     epsilon_term_ff     <= csr_wr_data;
            CSR_BIAS_CORR_FIRST:  bias_corr_first_ff  <= csr_wr_data;
            CSR_BIAS_CORR_SECOND: bias_corr_second_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      meta1_in.cmd         = cmd_type'(req_tuser);
      meta1_in.idx         = req_tdata[ADDR_W-1:0];
      meta1_in.load_weight = req_tdata[107:76];
      meta1_in.moment      = '0;
      meta1_in.velocity    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[1] <= req_tvalid;
         for (int k = 2; k <= LAST; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meta_ff[1] <= meta1_in;
         for (int k = 2; k <= LAST; k++) begin
            meta_ff[k] <= (k == 7) ? meta7_in : meta_ff[k-1];
         end
      end
   end

   always_comb begin
      b1c_in = (BETA_W+1)'(BETA_ONE) - {1'b0, beta_first_ff};
      b2c_in = (BETA_W+1)'(BETA_ONE) - {1'b0, beta_second_ff};
      cm_in  = 50'($signed({1'b0, b1c_in})) * 50'(s2_g_ff);
      cv_in  = 49'(b2c_in) * 49'(s4_g2_ff);
      sum_in = {1'b0, s9_vhat_ff} + {1'b0, epsilon_term_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff   <= 64'($signed(req_tdata[43:12])) * 64'($signed(req_tdata[75:44]));
         s2_g_ff      <= $signed(sat_s32(s1_prod_ff >>> FRAC_W));
         s3_gg_ff     <= 64'(64'(s2_g_ff) * 64'(s2_g_ff));
         s3_cm_ff     <= cm_in;
         s4_g2_ff     <= sat_u32(s3_gg_ff >> FRAC_W);
         s4_cm_ff     <= s3_cm_ff;
         s5_cv_ff     <= cv_in;
         s5_cm_ff     <= s4_cm_ff;
         s6_cv_ff     <= s5_cv_ff;
         s6_cm_ff     <= s5_cm_ff;
         s8_mhat_ff   <= 64'($signed(meta_ff[7].moment)) *
                         64'($signed({1'b0, bias_corr_first_ff}));
         s8_vhat_ff   <= 64'(meta_ff[7].velocity) * 64'(bias_corr_second_ff);
         s9_mhat_ff   <= sat_s32(s8_mhat_ff >>> FRAC_W);
         s9_vhat_ff   <= sat_u32(s8_vhat_ff >> FRAC_W);
         s10_sum_ff   <= sum_in[WORD_W] ? '1 : sum_in[WORD_W-1:0];
         s10_mag_ff   <= s9_mhat_ff[WORD_W-1] ? WORD_W'(-s9_mhat_ff) : s9_mhat_ff;
         s10_neg_ff   <= s9_mhat_ff[WORD_W-1];
         s11_num_ff   <= 64'(s10_mag_ff) * 64'(learning_rate_ff);
         s11_rad_ff   <= {s10_sum_ff, FRAC_W'(0)};
         s11_neg_ff   <= s10_neg_ff;
         s11_fault_ff <= (s10_sum_ff == '0);
      end
   end

   awu_ram #(
      .WIDTH (2 * WORD_W),
      .DEPTH (ENTRIES)
   ) u_moment_ram (
      .clock   (clock),
      .wr_en   (mv_wr_en),
      .wr_addr (meta_ff[6].idx),
      .wr_data ({meta7_in.velocity, meta7_in.moment}),
      .rd_en   (advance),
      .rd_addr (meta_ff[5].idx),
      .rd_data (mv_q)
   );

   always_comb begin
      mv_fwd   = valid_ff[7] && (meta_ff[7].idx == meta_ff[6].idx);
      m_old    = mv_fwd ? meta_ff[7].moment   : mv_q[WORD_W-1:0];
      v_old    = mv_fwd ? meta_ff[7].velocity : mv_q[2*WORD_W-1:WORD_W];
      m_sum_in = 50'($signed({1'b0, beta_first_ff})) * 50'($signed(m_old)) + s6_cm_ff;
      v_sum_in = 49'(beta_second_ff) * 49'(v_old) + s6_cv_ff;
      meta7_in = meta_ff[6];
      mv_wr_en = 1'b0;
      unique case (meta_ff[6].cmd)
         CMD_LOAD: begin
            meta7_in.moment   = '0;
            meta7_in.velocity = '0;
            mv_wr_en          = advance && valid_ff[6];
         end
         CMD_UPDATE: begin
            meta7_in.moment   = m_sum_in[47:16];
            meta7_in.velocity = v_sum_in[47:16];
            mv_wr_en          = advance && valid_ff[6];
         end
         default: begin
            meta7_in.moment   = m_old;
            meta7_in.velocity = v_old;
         end
      endcase
   end

   assign rd_ctl_in = '{meta: meta_ff[LAST], neg: s11_neg_ff, fault: s11_fault_ff};

   awu_root_div u_root_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (valid_ff[LAST]),
      .in_ctl    (rd_ctl_in),
      .in_num    (s11_num_ff),
      .in_rad    (s11_rad_ff),
      .out_valid (rd_valid),
      .out_ctl   (rd_ctl),
      .out_quo   (rd_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else if (advance) begin
         w_valid_ff <= rd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w_ctl_ff <= rd_ctl;
         w_quo_ff <= rd_quo;
      end
   end

   awu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_ctl_ff.meta.idx),
      .wr_data (w_new_in),
      .rd_en   (advance),
      .rd_addr (rd_ctl.meta.idx),
      .rd_data (w_q)
   );

   always_comb begin
      w_fwd     = rsp_valid_ff && (rsp_idx_ff == w_ctl_ff.meta.idx);
      w_old     = w_fwd ? rsp_weight_ff : w_q;
      delta_in  = w_ctl_ff.neg ? -$signed({1'b0, w_quo_ff}) : $signed({1'b0, w_quo_ff});
      w_diff_in = 64'($signed(w_old)) - 64'(delta_in);
      w_new_in  = w_old;
      fault_in  = 1'b0;
      w_wr_en   = 1'b0;
      unique case (w_ctl_ff.meta.cmd)
         CMD_LOAD: begin
            w_new_in = w_ctl_ff.meta.load_weight;
            w_wr_en  = advance && w_valid_ff;
         end
         CMD_UPDATE: begin
            fault_in = w_ctl_ff.fault;
            if (!w_ctl_ff.fault) begin
               w_new_in = sat_s32(w_diff_in);
               w_wr_en  = advance && w_valid_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= w_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_weight_ff   <= w_new_in;
         rsp_moment_ff   <= w_ctl_ff.meta.moment;
         rsp_velocity_ff <= w_ctl_ff.meta.velocity;
         rsp_fault_ff    <= fault_in;
         rsp_idx_ff      <= w_ctl_ff.meta.idx;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_velocity_ff, rsp_moment_ff, rsp_weight_ff};
   assign rsp_tuser  = rsp_fault_ff;

endmodule

/* design/awu_checker.sv */
// Port-level checker for the Adam weight-update unit and its bind.
module awu_checker import awu_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [111:0]         req_tdata,
   input logic [1:0]           req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [95:0]          rsp_tdata,
   input logic [0:0]           rsp_tuser,
   input logic                 csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [WORD_W-1:0]    csr_wr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_free_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty result register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind adam_weight_update_unit awu_checker u_awu_checker (.*);

/* test/awu_checker.sv */
// Checker for the Adam weight-update unit: watches requests and responses and predicts results.
module awu_scoreboard import awu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [111:0]         req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [95:0]          rsp_tdata,
   input  logic [0:0]           rsp_tuser,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wr_data,
   output int                   fail_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [31:0] weight;
      logic [31:0] moment;
      logic [31:0] velocity;
      logic        fault;
   } entry_result_type;

   logic [15:0] beta1, beta2;
   logic [31:0] lrate, eps, bc1, bc2;
   logic [31:0] weights [ENTRIES];
   logic [31:0] moments [ENTRIES];
   logic [31:0] velocities [ENTRIES];
   entry_result_type expected_results [$];

   function automatic longint floor_div24(longint v);
      return v >>> 24;
   endfunction

   function automatic longint clamp_s32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned clamp_u32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic entry_result_type apply_command(cmd_type cmd, logic [11:0] idx,
         logic [31:0] x_raw, logic [31:0] dy_raw, logic [31:0] w_raw);
      entry_result_type r;
      longint x, dy, g, m, mhat, delta, w;
      longint unsigned g2, v, vhat, s, root, mag, q;
      r.fault = 1'b0;
      if (cmd == CMD_LOAD) begin
         weights[idx] = w_raw;
         moments[idx] = '0;
         velocities[idx] = '0;
      end else if (cmd == CMD_UPDATE) begin
         x = longint'($signed(x_raw));
         dy = longint'($signed(dy_raw));
         g = clamp_s32(floor_div24(x * dy));
         m = clamp_s32((longint'(beta1) * longint'($signed(moments[idx]))
               + (65536 - longint'(beta1)) * g) >>> 16);
         g2 = clamp_u32(longint'(g * g) >> 24);
         v = clamp_u32((longint'(beta2) * longint'(velocities[idx])
               + (65536 - longint'(beta2)) * g2) >> 16);
         moments[idx] = m[31:0];
         velocities[idx] = v[31:0];
         mhat = clamp_s32(floor_div24(m * longint'(bc1)));
         vhat = clamp_u32((v * longint'(bc2)) >> 24);
         s = clamp_u32(vhat + longint'(eps));
         root = int_sqrt(s << 24);
         if (root == 0) begin
            r.fault = 1'b1;
         end else begin
            mag = (mhat < 0) ? longint'(-mhat) : longint'(mhat);
            q = (mag * longint'(lrate)) / root;
            if (q > (64'd1 << 33)) q = 64'd1 << 33;
            delta = (mhat < 0) ? -longint'(q) : longint'(q);
            w = clamp_s32(longint'($signed(weights[idx])) - delta);
            weights[idx] = w[31:0];
         end
      end
      r.weight = weights[idx];
      r.moment = moments[idx];
      r.velocity = velocities[idx];
      return r;
   endfunction

   always @(posedge clock) begin
      entry_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         beta1 <= 16'd58982;
         beta2 <= 16'd65470;
         lrate <= 32'd16777;
         eps <= 32'd1;
         bc1 <= 32'd16777216;
         bc2 <= 32'd16777216;
         expected_results.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BETA_FIRST:       beta1 <= csr_wr_data[15:0];
               CSR_BETA_SECOND:      beta2 <= csr_wr_data[15:0];
               CSR_LEARNING_RATE:    lrate <= csr_wr_data;
               CSR_EPSILON_TERM:     eps <= csr_wr_data;
               CSR_BIAS_CORR_FIRST:  bc1 <= csr_wr_data;
               CSR_BIAS_CORR_SECOND: bc2 <= csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.weight) begin
                  $error("weight_value expected %h actual %h", want.weight, rsp_tdata[31:0]);
                  errs++;
               end
               if (rsp_tdata[63:32] !== want.moment) begin
                  $error("moment_value expected %h actual %h", want.moment,
                     rsp_tdata[63:32]);
                  errs++;
               end
               if (rsp_tdata[95:64] !== want.velocity) begin
                  $error("velocity_value expected %h actual %h", want.velocity,
                     rsp_tdata[95:64]);
                  errs++;
               end
               if (rsp_tuser[0] !== want.fault) begin
                  $error("div_fault expected %b actual %b", want.fault, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_command(cmd_type'(req_tuser), req_tdata[11:0],
               req_tdata[43:12], req_tdata[75:44], req_tdata[107:76]));
         end
         fail_count <= fail_count + errs;
         pending_count <= expected_results.size();
      end
   end

endmodule

/* test/tb_top.sv */
// Testbench top for the Adam weight-update unit: stimulus, flow control and verdict.
module tb_top;
   import awu_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [111:0]         req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [95:0]          rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wr_data = '0;
   int                   fail_count;
   int                   pending_count;
   int                   sink_idle_pct = 27;
   bit                   sink_hold = 1'b0;
   bit                   loaded [ENTRIES];
   logic [11:0]          hot_entries [8];

   always #5 clock = ~clock;

   adam_weight_update_unit dut (.*);

   awu_scoreboard checker_inst (.*);

   always @(posedge clock) begin
      if (reset || sink_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   task automatic send_request(cmd_type cmd, logic [11:0] idx, logic [31:0] x,
         logic [31:0] dy, logic [31:0] w, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'b0, w, dy, x, idx};
      if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (RD_LAT + 20) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'($signed($urandom_range(65535)) - 32768) <<< $urandom_range(24);
         default: return 32'($signed($urandom_range(2047)) - 1024) <<< 14;
      endcase
   endfunction

   task automatic random_phase(int count, int idle_pct);
      logic [11:0] idx;
      int          k;
      cmd_type     cmd;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         if (k < 30) idx = hot_entries[$urandom_range(7)];
         else idx = 12'($urandom());
         k = $urandom_range(99);
         if (!loaded[idx] || k < 15) cmd = CMD_LOAD;
         else if (k < 80) cmd = CMD_UPDATE;
         else cmd = CMD_READ;
         if (cmd != CMD_LOAD && $urandom_range(19) == 0) cmd = cmd_type'(2'd3);
         send_request(cmd, idx, pick_value(), pick_value(), pick_value(), idle_pct);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) hot_entries[i] = 12'($urandom());
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(CMD_LOAD, 12'd0, '0, '0, 32'h7FFF_FFFF, 0);
      send_request(CMD_LOAD, 12'hFFF, '0, '0, 32'h8000_0000, 0);
      send_request(CMD_LOAD, 12'd5, '1, '1, 32'h0100_0000, 0);
      send_request(CMD_READ, 12'd0, '0, '0, '0, 0);
      send_request(cmd_type'(2'd3), 12'hFFF, '0, '0, '0, 0);
      send_request(CMD_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 0);
      send_request(CMD_UPDATE, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, 0);
      send_request(CMD_UPDATE, 12'd5, 32'h8000_0000, 32'h8000_0000, '0, 0);
      send_request(CMD_UPDATE, 12'd5, 32'h0100_0000, 32'hFF00_0000, '0, 0);
      send_request(CMD_UPDATE, 12'd5, '0, '0, '0, 0);
      send_request(CMD_READ, 12'd5, '1, '1, '1, 0);
      drain();
      // zero denominator: no epsilon, no velocity until the last update
      write_csr(CSR_EPSILON_TERM, 32'd0);
      write_csr(CSR_BETA_FIRST, 32'd0);
      write_csr(CSR_BETA_SECOND, 32'hFFFF);
      send_request(CMD_LOAD, 12'd7, '0, '0, 32'h0123_4567, 0);
      send_request(CMD_UPDATE, 12'd7, '0, 32'h0100_0000, '0, 0);
      send_request(CMD_UPDATE, 12'd7, 32'h0000_0001, 32'h0000_0001, '0, 0);
      send_request(CMD_UPDATE, 12'd7, 32'h0100_0000, 32'h0100_0000, '0, 0);
      drain();
      write_csr(CSR_BETA_FIRST, 32'd58982);
      write_csr(CSR_BETA_SECOND, 32'd65470);
      write_csr(CSR_EPSILON_TERM, 32'd1);
      sink_idle_pct = 0;
      random_phase(100, 0);
      drain();
      sink_idle_pct = 27;
      write_csr(CSR_LEARNING_RATE, 32'hFFFF_FFFF);
      write_csr(CSR_BIAS_CORR_FIRST, 32'hFFFF_FFFF);
      write_csr(CSR_BIAS_CORR_SECOND, 32'hFFFF_FFFF);
      write_csr(CSR_EPSILON_TERM, 32'hFFFF_FFFF);
      fork
         begin
            sink_hold = 1'b1;
            repeat (300) @(posedge clock);
            sink_hold = 1'b0;
         end
         random_phase(150, 27);
      join
      drain();
      write_csr(CSR_BETA_FIRST, 32'hFFFF);
      write_csr(CSR_BETA_SECOND, 32'd0);
      write_csr(CSR_LEARNING_RATE, 32'd0);
      write_csr(CSR_BIAS_CORR_FIRST, 32'd0);
      write_csr(CSR_BIAS_CORR_SECOND, 32'd0);
      write_csr(CSR_EPSILON_TERM, 32'd0);
      random_phase(100, 27);
      drain();
      write_csr(CSR_BETA_FIRST, $urandom_range(65535));
      write_csr(CSR_BETA_SECOND, $urandom_range(65535));
      write_csr(CSR_LEARNING_RATE, $urandom());
      write_csr(CSR_EPSILON_TERM, $urandom_range(255));
      write_csr(CSR_BIAS_CORR_FIRST, 32'h0100_0000 + $urandom_range(32'h0400_0000));
      write_csr(CSR_BIAS_CORR_SECOND, 32'h0100_0000 + $urandom_range(32'h0400_0000));
      random_phase(200, 27);
      drain();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
